>>> rtl/mtxc_pkg.sv
// Package: shared constants, types and functions for the MT19937 xor-chain cipher.
`timescale 1ns / 1ps
package mtxc_pkg;

   localparam int KEY_WORDS_DEF = 16;
   localparam int MT_N = 624;
   localparam int MT_M = 397;
   localparam int IDX_W = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_REGS = 8;

   localparam logic [31:0] SEED_INIT = 32'd19650218;
   localparam logic [31:0] MUL_INIT = 32'd1812433253;
   localparam logic [31:0] MUL_KEY = 32'd1664525;
   localparam logic [31:0] MUL_MIX = 32'd1566083941;
   localparam logic [31:0] MATRIX_A = 32'h9908b0df;
   localparam logic [31:0] UPPER_MASK = 32'h80000000;

   // command sent from front to back
   typedef struct packed {
      logic        reseed;
      logic [31:0] data;
      logic [2:0]  vbytes;
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT_RD, ST_INIT_MUL, ST_INIT_WR,
      ST_KEY_RD, ST_KEY_RD2, ST_KEY_MUL, ST_KEY_WR,
      ST_MIX_RD, ST_MIX_RD2, ST_MIX_MUL, ST_MIX_WR,
      ST_FIX0_RD, ST_FIX0_WR,
      ST_TW_RD0, ST_TW_RD1, ST_TW_RD2, ST_TW_WR,
      ST_DRAW_RD, ST_DRAW_WAIT, ST_DRAW_USE,
      ST_OUT
   } back_state_type;

   function automatic logic [31:0] temper(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic [31:0] byte_mask(input logic [2:0] vb);
      logic [31:0] m;
      case (vb)
         3'd0: m = 32'h0000_0000;
         3'd1: m = 32'h0000_00ff;
         3'd2: m = 32'h0000_ffff;
         3'd3: m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

>>> rtl/mtxc_front.sv
// Front end: accepts items, classifies reseed, two-entry queue to the back end.
`timescale 1ns / 1ps
module mtxc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_first,
   input  logic [31:0]          req_data_in,
   input  logic [2:0]           req_valid_bytes,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output mtxc_pkg::cmd_type    cmd
);
   mtxc_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       seeded_ff, seeded_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[rd_ff];

   // queue pointers and seeded flag
   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
      seeded_in = seeded_ff | push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         seeded_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         seeded_ff <= seeded_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= '{reseed: req_first | ~seeded_ff, data: req_data_in,
                          vbytes: req_valid_bytes};
      end
   end
endmodule

>>> rtl/mtxc_back.sv
// Back end: MT19937 state memory, seeding sequencer, twist, draw and xor chain.
`timescale 1ns / 1ps
module mtxc_back #(
   parameter int KEY_WORDS = mtxc_pkg::KEY_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  mtxc_pkg::cmd_type    cmd,
   input  logic [63:0]          key_pairs [KEY_WORDS/2],
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_data_out,
   output logic [2:0]           rsp_out_valid_bytes
);
   localparam int IW = mtxc_pkg::IDX_W;
   localparam int KW = $clog2(KEY_WORDS);
   localparam logic [IW-1:0] LAST = IW'(mtxc_pkg::MT_N - 1);
   localparam logic [IW-1:0] NPOS = IW'(mtxc_pkg::MT_N);
   localparam int KEY_LOOPS = (mtxc_pkg::MT_N > KEY_WORDS) ? mtxc_pkg::MT_N : KEY_WORDS;

   // state memory, one write port and one registered read port
   logic [31:0] mem [mtxc_pkg::MT_N];
   logic [31:0] rdata_ff;
   logic [IW-1:0] raddr, waddr;
   logic [31:0] wdata;
   logic          we;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   mtxc_pkg::back_state_type st_ff, st_in;
   logic [IW-1:0] i_ff, i_in, pos_ff, pos_in;
   logic [KW-1:0] j_ff, j_in;
   logic [IW:0]   k_ff, k_in;
   logic [31:0]   a_ff, a_in, b_ff, b_in, prod_ff, prod_in;
   logic [31:0]   chain_ff [4];
   logic [31:0]   chain_in [4];
   logic [2:0]    prime_ff, prime_in;
   logic          prime_mode_ff, prime_mode_in;
   mtxc_pkg::cmd_type cur_ff, cur_in;
   logic          ov_ff, ov_in;
   logic [31:0]   od_ff, od_in;
   logic [2:0]    ob_ff, ob_in;
   logic [31:0]   p, v, y, keyw;
   logic [63:0]   kp;
   logic [IW-1:0] i_next, n1, nm;

   assign rsp_valid = ov_ff;
   assign rsp_data_out = od_ff;
   assign rsp_out_valid_bytes = ob_ff;

   always_comb begin
      kp = key_pairs[j_ff[KW-1:1]];
      keyw = j_ff[0] ? kp[63:32] : kp[31:0];
      p = a_ff ^ (a_ff >> 30);
      i_next = (i_ff == LAST) ? IW'(1) : i_ff + IW'(1);
      n1 = (i_ff == LAST) ? IW'(0) : i_ff + IW'(1);
      nm = (i_ff >= IW'(mtxc_pkg::MT_N - mtxc_pkg::MT_M)) ?
           i_ff - IW'(mtxc_pkg::MT_N - mtxc_pkg::MT_M) : i_ff + IW'(mtxc_pkg::MT_M);
      v = (a_ff & mtxc_pkg::UPPER_MASK) | (b_ff & ~mtxc_pkg::UPPER_MASK);
      y = mtxc_pkg::temper(rdata_ff);
   end

   // sequencer
   always_comb begin
      st_in = st_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      a_in = a_ff; b_in = b_ff; prod_in = prod_ff; pos_in = pos_ff;
      prime_in = prime_ff; prime_mode_in = prime_mode_ff; cur_in = cur_ff;
      ov_in = ov_ff; od_in = od_ff; ob_in = ob_ff;
      for (int c = 0; c < 4; c++) chain_in[c] = chain_ff[c];
      raddr = i_ff; waddr = i_ff; wdata = 32'd0; we = 1'b0;
      cmd_ready = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (st_ff)
         // next item may enter while the previous result leaves
         mtxc_pkg::ST_IDLE: begin
            if (cmd_valid && (!ov_ff || rsp_ready)) begin
               cmd_ready = 1'b1;
               cur_in = cmd;
               if (cmd.reseed) begin
                  we = 1'b1; waddr = IW'(0); wdata = mtxc_pkg::SEED_INIT;
                  a_in = mtxc_pkg::SEED_INIT; i_in = IW'(1);
                  st_in = mtxc_pkg::ST_INIT_MUL;
               end else begin
                  prime_mode_in = 1'b0; st_in = mtxc_pkg::ST_DRAW_RD;
               end
            end
         end
         // linear init: a holds previous word
         mtxc_pkg::ST_INIT_MUL: begin
            prod_in = mtxc_pkg::MUL_INIT * p; st_in = mtxc_pkg::ST_INIT_WR;
         end
         mtxc_pkg::ST_INIT_WR: begin
            we = 1'b1; wdata = prod_ff + 32'(i_ff); a_in = wdata;
            if (i_ff == LAST) begin
               i_in = IW'(1); j_in = '0; k_in = (IW+1)'(KEY_LOOPS);
               st_in = mtxc_pkg::ST_KEY_RD;
            end else begin
               i_in = i_ff + IW'(1); st_in = mtxc_pkg::ST_INIT_MUL;
            end
         end
         mtxc_pkg::ST_INIT_RD: st_in = mtxc_pkg::ST_KEY_RD;
         // key mixing: read mem[i-1] then mem[i]
         mtxc_pkg::ST_KEY_RD: begin
            raddr = i_ff - IW'(1); st_in = mtxc_pkg::ST_KEY_RD2;
         end
         mtxc_pkg::ST_KEY_RD2: begin
            a_in = rdata_ff; raddr = i_ff; st_in = mtxc_pkg::ST_KEY_MUL;
         end
         mtxc_pkg::ST_KEY_MUL: begin
            b_in = rdata_ff; prod_in = p * mtxc_pkg::MUL_KEY;
            st_in = mtxc_pkg::ST_KEY_WR;
         end
         mtxc_pkg::ST_KEY_WR: begin
            we = 1'b1; wdata = (b_ff ^ prod_ff) + keyw + 32'(j_ff);
            a_in = wdata;
            j_in = (32'(j_ff) == KEY_WORDS - 1) ? '0 : j_ff + KW'(1);
            k_in = k_ff - (IW+1)'(1);
            if (i_ff == LAST) begin
               i_in = IW'(1); st_in = mtxc_pkg::ST_FIX0_WR; prime_mode_in = 1'b0;
            end else begin
               i_in = i_next;
               st_in = (k_ff == (IW+1)'(1)) ? mtxc_pkg::ST_MIX_RD : mtxc_pkg::ST_KEY_RD;
               if (k_ff == (IW+1)'(1)) k_in = (IW+1)'(mtxc_pkg::MT_N - 1);
            end
         end
         // mem[0] = mem[N-1]; a already holds it
         mtxc_pkg::ST_FIX0_WR: begin
            we = 1'b1; waddr = IW'(0); wdata = a_ff;
            if (k_ff == '0) begin
               k_in = (IW+1)'(mtxc_pkg::MT_N - 1);
               st_in = prime_mode_ff ? mtxc_pkg::ST_FIX0_RD : mtxc_pkg::ST_MIX_RD;
            end else if (prime_mode_ff) begin
               st_in = mtxc_pkg::ST_MIX_RD;
            end else begin
               st_in = mtxc_pkg::ST_KEY_RD;
            end
         end
         mtxc_pkg::ST_MIX_RD: begin
            raddr = i_ff - IW'(1); st_in = mtxc_pkg::ST_MIX_RD2;
         end
         mtxc_pkg::ST_MIX_RD2: begin
            a_in = rdata_ff; raddr = i_ff; st_in = mtxc_pkg::ST_MIX_MUL;
         end
         mtxc_pkg::ST_MIX_MUL: begin
            b_in = rdata_ff; prod_in = p * mtxc_pkg::MUL_MIX;
            st_in = mtxc_pkg::ST_MIX_WR;
         end
         mtxc_pkg::ST_MIX_WR: begin
            we = 1'b1; wdata = (b_ff ^ prod_ff) - 32'(i_ff); a_in = wdata;
            k_in = k_ff - (IW+1)'(1);
            if (i_ff == LAST) begin
               i_in = IW'(1); prime_mode_in = 1'b1; st_in = mtxc_pkg::ST_FIX0_WR;
            end else begin
               i_in = i_next;
               st_in = (k_ff == (IW+1)'(1)) ? mtxc_pkg::ST_FIX0_RD : mtxc_pkg::ST_MIX_RD;
            end
         end
         // final mem[0] and start priming draws
         mtxc_pkg::ST_FIX0_RD: begin
            we = 1'b1; waddr = IW'(0); wdata = mtxc_pkg::UPPER_MASK;
            pos_in = NPOS; prime_in = 3'd0; prime_mode_in = 1'b1;
            st_in = mtxc_pkg::ST_DRAW_RD;
         end
         // draw: twist when exhausted
         mtxc_pkg::ST_DRAW_RD: begin
            if (pos_ff >= NPOS) begin
               i_in = IW'(0); st_in = mtxc_pkg::ST_TW_RD0;
            end else begin
               raddr = pos_ff; st_in = mtxc_pkg::ST_DRAW_USE;
            end
         end
         mtxc_pkg::ST_TW_RD0: begin
            raddr = i_ff; st_in = mtxc_pkg::ST_TW_RD1;
         end
         mtxc_pkg::ST_TW_RD1: begin
            a_in = rdata_ff; raddr = n1; st_in = mtxc_pkg::ST_TW_RD2;
         end
         mtxc_pkg::ST_TW_RD2: begin
            b_in = rdata_ff; raddr = nm; st_in = mtxc_pkg::ST_TW_WR;
         end
         mtxc_pkg::ST_TW_WR: begin
            we = 1'b1;
            wdata = rdata_ff ^ (v >> 1) ^ (v[0] ? mtxc_pkg::MATRIX_A : 32'd0);
            if (i_ff == LAST) begin
               pos_in = IW'(0); st_in = mtxc_pkg::ST_DRAW_RD;
            end else begin
               i_in = i_ff + IW'(1); st_in = mtxc_pkg::ST_TW_RD0;
            end
         end
         mtxc_pkg::ST_DRAW_USE: begin
            pos_in = pos_ff + IW'(1);
            if (prime_mode_ff) begin
               chain_in[prime_ff[1:0]] = y;
               prime_in = prime_ff + 3'd1;
               if (prime_ff == 3'd3) prime_mode_in = 1'b0;
               st_in = mtxc_pkg::ST_DRAW_RD;
            end else begin
               od_in = (y ^ chain_ff[3] ^ chain_ff[2] ^ chain_ff[1] ^ chain_ff[0]
                        ^ cur_ff.data) & mtxc_pkg::byte_mask(cur_ff.vbytes);
               ob_in = cur_ff.vbytes; ov_in = 1'b1;
               chain_in[0] = {chain_ff[1][14:0], chain_ff[1][31:15]};
               chain_in[1] = {chain_ff[2][20:0], chain_ff[2][31:21]};
               chain_in[2] = {chain_ff[3][24:0], chain_ff[3][31:25]};
               chain_in[3] = {y[12:0], y[31:13]};
               st_in = mtxc_pkg::ST_IDLE;
            end
         end
         default: st_in = mtxc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mtxc_pkg::ST_IDLE;
         pos_ff <= '0;
         ov_ff <= 1'b0;
         prime_mode_ff <= 1'b0;
         prime_ff <= '0;
         for (int c = 0; c < 4; c++) chain_ff[c] <= '0;
      end else begin
         st_ff <= st_in;
         pos_ff <= pos_in;
         ov_ff <= ov_in;
         prime_mode_ff <= prime_mode_in;
         prime_ff <= prime_in;
         for (int c = 0; c < 4; c++) chain_ff[c] <= chain_in[c];
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      a_ff <= a_in; b_ff <= b_in; prod_ff <= prod_in;
      cur_ff <= cur_in; od_ff <= od_in; ob_ff <= ob_in;
   end
endmodule

>>> rtl/mt19937_xor_chain_stream_cipher_core.sv
// Top level: key registers, front end, back end of the MT19937 xor-chain cipher.
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | first, data_in, valid_bytes
//  rsp     | out       | rsp_valid / rsp_ready  | data_out, out_valid_bytes
//  csr     | in        | csr_valid / csr_ready  | index, wdata (64-bit key pair)
// A plain word passes the back end as accept, read and use; a result held
// on rsp blocks the next accept until it leaves. An exhausted state memory adds a
// twist, three reads and one write per state word. A reseed runs init (623 words),
// key mix (624 words), final mix (623 words), a full twist and five draws.
// Synchronous reset clears control; the memory needs no clearing since the first
// item reseeds. The two-entry front queue keeps accepting while the back stalls, until it is full.
`timescale 1ns / 1ps
module mt19937_xor_chain_stream_cipher_core #(
   parameter int KEY_WORDS = mtxc_pkg::KEY_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_first,
   input  logic [31:0] req_data_in,
   input  logic [2:0]  req_valid_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_data_out,
   output logic [2:0]  rsp_out_valid_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mtxc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0] csr_wdata
);
   logic [63:0] key_ff [KEY_WORDS/2];
   logic        cmd_valid, cmd_ready;
   mtxc_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   // key register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < KEY_WORDS/2; r++) key_ff[r] <= '0;
      end else if (csr_valid) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   mtxc_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_first, .req_data_in,
      .req_valid_bytes, .cmd_valid, .cmd_ready, .cmd
   );

   mtxc_back #(.KEY_WORDS(KEY_WORDS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd, .key_pairs(key_ff),
      .rsp_valid, .rsp_ready, .rsp_data_out, .rsp_out_valid_bytes
   );
endmodule

>>> rtl/mtxc_checker.sv
// Port-level checker for the cipher core, bound to the top level.
`timescale 1ns / 1ps
module mtxc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_data_out,
   input logic [2:0]  rsp_out_valid_bytes,
   input logic        csr_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out))
      else $error("rsp dropped while stalled");
   a_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid_bytes == 3'd1 |-> rsp_data_out[31:8] == 24'd0)
      else $error("tail bytes not zero");
   a_mask2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid_bytes == 3'd2 |-> rsp_data_out[31:16] == 16'd0)
      else $error("tail bytes not zero");
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");
endmodule

bind mt19937_xor_chain_stream_cipher_core mtxc_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_data_out, .rsp_out_valid_bytes,
   .csr_ready
);

>>> sim/testbench.sv
// Testbench for the MT19937 xor-chain stream cipher core: key setup, message traffic, checking.
`timescale 1ns / 1ps
module testbench;

   localparam logic [mtxc_pkg::CSR_IDX_W-1:0] KEY_PAIR0 = 3'd0;
   localparam int CYCLE_LIMIT = 5_000_000;

   typedef struct {
      logic        first;
      logic [31:0] data;
      logic [2:0]  vbytes;
   } word_item_type;

   typedef struct {
      logic [31:0] data;
      logic [2:0]  vbytes;
   } cipher_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_first = 1'b0;
   logic [31:0] req_data_in = '0;
   logic [2:0]  req_valid_bytes = 3'd4;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_data_out;
   logic [2:0]  rsp_out_valid_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [mtxc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   mt19937_xor_chain_stream_cipher_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the cipher: key, generator state, xor chain
   logic [63:0] key_shadow [mtxc_pkg::CSR_REGS];
   logic [31:0] gen_state [mtxc_pkg::MT_N];
   int          gen_pos;
   logic [31:0] chain [4];
   bit          keyed;

   word_item_type   pending_words[$];
   cipher_word_type expected_words[$];

   int  mismatches, words_sent, words_checked, reseeds;
   bit  no_idle;
   int  send_gap, stall_left;

   function automatic logic [31:0] key_word(int idx);
      logic [63:0] p;
      p = key_shadow[(idx >> 1) & 7];
      return (idx & 1) ? p[63:32] : p[31:0];
   endfunction

   function automatic void reseed_generator();
      int i, j, k;
      logic [31:0] p;
      gen_state[0] = mtxc_pkg::SEED_INIT;
      for (i = 1; i < mtxc_pkg::MT_N; i++) begin
         p = gen_state[i-1];
         gen_state[i] = mtxc_pkg::MUL_INIT * (p ^ (p >> 30)) + 32'(i);
      end
      i = 1;
      j = 0;
      for (k = mtxc_pkg::MT_N; k > 0; k--) begin
         p = gen_state[i-1];
         gen_state[i] = (gen_state[i] ^ ((p ^ (p >> 30)) * mtxc_pkg::MUL_KEY))
                        + key_word(j) + 32'(j);
         i++;
         j++;
         if (i >= mtxc_pkg::MT_N) begin
            gen_state[0] = gen_state[mtxc_pkg::MT_N-1];
            i = 1;
         end
         if (j >= mtxc_pkg::KEY_WORDS_DEF) j = 0;
      end
      for (k = mtxc_pkg::MT_N - 1; k > 0; k--) begin
         p = gen_state[i-1];
         gen_state[i] = (gen_state[i] ^ ((p ^ (p >> 30)) * mtxc_pkg::MUL_MIX)) - 32'(i);
         i++;
         if (i >= mtxc_pkg::MT_N) begin
            gen_state[0] = gen_state[mtxc_pkg::MT_N-1];
            i = 1;
         end
      end
      gen_state[0] = mtxc_pkg::UPPER_MASK;
      gen_pos = mtxc_pkg::MT_N;
   endfunction

   function automatic logic [31:0] next_keystream();
      logic [31:0] v, y;
      if (gen_pos >= mtxc_pkg::MT_N) begin
         for (int n = 0; n < mtxc_pkg::MT_N; n++) begin
            v = (gen_state[n] & mtxc_pkg::UPPER_MASK)
                | (gen_state[(n+1) % mtxc_pkg::MT_N] & ~mtxc_pkg::UPPER_MASK);
            gen_state[n] = gen_state[(n + mtxc_pkg::MT_M) % mtxc_pkg::MT_N] ^ (v >> 1)
                           ^ (v[0] ? mtxc_pkg::MATRIX_A : 32'h0);
         end
         gen_pos = 0;
      end
      y = gen_state[gen_pos];
      gen_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // Cipher one accepted word and queue the expected output
   function automatic void cipher_word(logic first, logic [31:0] data, logic [2:0] vb);
      logic [31:0] c4, mask;
      cipher_word_type w;
      if (first || !keyed) begin
         reseed_generator();
         for (int n = 0; n < 4; n++) chain[n] = next_keystream();
         keyed = 1'b1;
         reseeds++;
      end
      c4 = next_keystream();
      mask = (vb >= 3'd4) ? 32'hffff_ffff : 32'((64'd1 << (8 * vb)) - 1);
      w.data = (c4 ^ chain[3] ^ chain[2] ^ chain[1] ^ chain[0] ^ data) & mask;
      w.vbytes = vb;
      chain[0] = {chain[1][14:0], chain[1][31:15]};
      chain[1] = {chain[2][20:0], chain[2][31:21]};
      chain[2] = {chain[3][24:0], chain[3][31:25]};
      chain[3] = {c4[12:0], c4[31:13]};
      expected_words.push_back(w);
   endfunction

   // Mostly short gaps, a few long ones; none in burst stretches
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // Request driver
   always @(posedge clock) begin
      word_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            cipher_word(req_first, req_data_in, req_valid_bytes);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               it = pending_words.pop_front();
               req_valid <= 1'b1;
               req_first <= it.first;
               req_data_in <= it.data;
               req_valid_bytes <= it.vbytes;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure
   always @(posedge clock) begin
      cipher_word_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected output word data=%h vb=%0d", rsp_data_out,
                           rsp_out_valid_bytes);
            end else begin
               w = expected_words.pop_front();
               if (w.data !== rsp_data_out || w.vbytes !== rsp_out_valid_bytes) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word %0d: expected data=%h vb=%0d, got data=%h vb=%0d",
                              words_checked, w.data, w.vbytes, rsp_data_out,
                              rsp_out_valid_bytes);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Run limit
   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_key_pair(int k, logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= KEY_PAIR0 + k[mtxc_pkg::CSR_IDX_W-1:0];
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      key_shadow[k] = value;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic add_word(logic first, logic [31:0] data, logic [2:0] vb);
      word_item_type it;
      it.first = first;
      it.data = data;
      it.vbytes = vb;
      pending_words.push_back(it);
   endtask

   // Well-formed message: first flag, full words, short tail; a little noise
   task automatic add_message(int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 4)
            add_word(1'($urandom_range(1)), $urandom, 3'($urandom_range(7)));
         else if (i == len - 1 && $urandom_range(1))
            add_word(i == 0, $urandom, 3'($urandom_range(3, 1)));
         else
            add_word(i == 0, $urandom, 3'd4);
      end
   endtask

   task automatic load_keys(int mode);
      for (int k = 0; k < mtxc_pkg::CSR_REGS; k++)
         case (mode)
            0: write_key_pair(k, 64'h0);
            1: write_key_pair(k, 64'hffff_ffff_ffff_ffff);
            default: write_key_pair(k, {$urandom, $urandom});
         endcase
   endtask

   initial begin
      for (int k = 0; k < mtxc_pkg::CSR_REGS; k++) key_shadow[k] = '0;
      for (int n = 0; n < mtxc_pkg::MT_N; n++) gen_state[n] = '0;
      for (int n = 0; n < 4; n++) chain[n] = '0;
      gen_pos = 0;
      keyed = 1'b0;
      mismatches = 0;
      words_sent = 0;
      words_checked = 0;
      reseeds = 0;
      no_idle = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset keys, first word without the flag must still reseed
      add_word(1'b0, 32'h0000_0000, 3'd4);
      add_word(1'b0, 32'hffff_ffff, 3'd4);
      add_word(1'b0, 32'hffff_ffff, 3'd1);
      add_word(1'b0, 32'hffff_ffff, 3'd2);
      add_word(1'b0, 32'hffff_ffff, 3'd3);
      add_word(1'b0, 32'hffff_ffff, 3'd0);
      add_word(1'b0, 32'hffff_ffff, 3'd5);
      add_word(1'b0, 32'hffff_ffff, 3'd7);
      add_word(1'b1, 32'h0123_4567, 3'd4);
      add_word(1'b1, 32'h89ab_cdef, 3'd6);
      add_word(1'b0, 32'h0000_0000, 3'd3);
      wait_drained();

      // All-ones key, then one long message that runs past a twist
      load_keys(1);
      no_idle = 1'b1;
      add_message(700);
      wait_drained();
      no_idle = 1'b0;

      // Random keys, random messages, with a zero-key phase in between
      for (int phase = 0; phase < 4; phase++) begin
         load_keys(phase == 2 ? 0 : 2);
         no_idle = (phase == 1);
         for (int m = 0; m < 9; m++) add_message($urandom_range(25, 1));
         wait_drained();
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (100) @(posedge clock);
      if (expected_words.size() != 0) mismatches++;
      $display("covered %0d words, %0d checked, %0d key reseeds, in %0d cycles",
               words_sent, words_checked, reseeds, cycles);
      $display("keys: zero, all ones and random; tails, odd byte counts, twist crossing");
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
